@@ rtl/mrrc_pkg.sv @@
`default_nettype none

package mrrc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_STATION_ID    = 3'd0;
    localparam logic [2:0] REG_OPERATION     = 3'd1;
    localparam logic [2:0] REG_START_ADDRESS = 3'd2;
    localparam logic [2:0] REG_READ_COUNT    = 3'd3;
    localparam logic [2:0] REG_WRITE_VALUE   = 3'd4;
    localparam logic [2:0] REG_WRITE_COUNT   = 3'd5;

    // Operation codes.
    localparam logic [1:0] OP_READ         = 2'd0;
    localparam logic [1:0] OP_WRITE_SINGLE = 2'd1;
    localparam logic [1:0] OP_WRITE_MULTI  = 2'd2;

    // Modbus function codes.
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

    // Error codes.
    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_LENGTH      = 3'd1;
    localparam logic [2:0] ERR_READ_COUNT  = 3'd2;
    localparam logic [2:0] ERR_HEADER      = 3'd3;
    localparam logic [2:0] ERR_CRC         = 3'd4;
    localparam logic [2:0] ERR_ADDRESS     = 3'd5;
    localparam logic [2:0] ERR_DATA        = 3'd6;
    localparam logic [2:0] ERR_WRITE_COUNT = 3'd7;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  INDEX_MAX   = 8'hFF;

    typedef struct packed {
        logic [7:0]  station_id;
        logic [1:0]  operation;
        logic [15:0] start_address;
        logic [6:0]  read_count;
        logic [15:0] write_value;
        logic [15:0] write_count;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] error_code;
    } result_t;

    // One byte of the reflected Modbus CRC-16.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mrrc_cfg.sv @@
`default_nettype none

module mrrc_cfg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    output mrrc_pkg::cfg_t           cfg
);

    mrrc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.station_id    <= 8'd1;
            cfg_reg.operation     <= mrrc_pkg::OP_READ;
            cfg_reg.start_address <= 16'd0;
            cfg_reg.read_count    <= 7'd1;
            cfg_reg.write_value   <= 16'd0;
            cfg_reg.write_count   <= 16'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mrrc_pkg::REG_STATION_ID:    cfg_reg.station_id    <= cfg_data[7:0];
                mrrc_pkg::REG_OPERATION:     cfg_reg.operation     <= cfg_data[1:0];
                mrrc_pkg::REG_START_ADDRESS: cfg_reg.start_address <= cfg_data;
                mrrc_pkg::REG_READ_COUNT:    cfg_reg.read_count    <= cfg_data[6:0];
                mrrc_pkg::REG_WRITE_VALUE:   cfg_reg.write_value   <= cfg_data;
                mrrc_pkg::REG_WRITE_COUNT:   cfg_reg.write_count   <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/mrrc_core.sv @@
`default_nettype none

module mrrc_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mrrc_pkg::cfg_t     cfg,
    input  wire mrrc_pkg::in_word_t in_word,
    output logic                    in_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mrrc_pkg::result_t       result
);

    logic [7:0]  byte_index_reg;
    logic [7:0]  hdr_reg [6];
    logic [15:0] crc_now_reg;
    logic [15:0] crc_hist_reg;
    logic [7:0]  prev_byte_reg;
    logic        too_long_reg;

    logic              m_valid_reg;
    mrrc_pkg::result_t result_reg;

    logic              advance;
    logic [7:0]        hdr_cur [6];
    logic [8:0]        frame_len;
    logic              over;
    logic              crc_ok;
    logic [15:0]       addr;
    logic [15:0]       word45;
    logic [7:0]        fc_expect;
    logic [2:0]        err;

    // A non-final word never produces a verdict, so it can always move on.
    assign in_ready = !in_word.last || !m_valid_reg || m_ready;
    assign advance  = in_word.valid && in_ready;
    assign m_valid  = m_valid_reg;
    assign result   = result_reg;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            hdr_cur[k] = (byte_index_reg == 8'(k)) ? in_word.data : hdr_reg[k];
        end
    end

    always_comb begin
        frame_len = {1'b0, byte_index_reg} + 9'd1;
        over      = too_long_reg || (byte_index_reg == mrrc_pkg::INDEX_MAX);
        crc_ok    = (byte_index_reg != 8'd0) &&
                    (prev_byte_reg == crc_hist_reg[7:0]) &&
                    (in_word.data == crc_hist_reg[15:8]);
        addr      = {hdr_cur[2], hdr_cur[3]};
        word45    = {hdr_cur[4], hdr_cur[5]};
        fc_expect = (cfg.operation == mrrc_pkg::OP_WRITE_SINGLE) ?
                    mrrc_pkg::FC_WRITE_SINGLE : mrrc_pkg::FC_WRITE_MULTI;
        err       = mrrc_pkg::ERR_OK;
        if (cfg.operation == mrrc_pkg::OP_WRITE_SINGLE ||
            cfg.operation == mrrc_pkg::OP_WRITE_MULTI) begin
            if (over || frame_len != 9'd8) begin
                err = mrrc_pkg::ERR_LENGTH;
            end else if (hdr_cur[0] != cfg.station_id || hdr_cur[1] != fc_expect) begin
                err = mrrc_pkg::ERR_HEADER;
            end else if (!crc_ok) begin
                err = mrrc_pkg::ERR_CRC;
            end else if (addr != cfg.start_address) begin
                err = mrrc_pkg::ERR_ADDRESS;
            end else if (cfg.operation == mrrc_pkg::OP_WRITE_SINGLE &&
                         word45 != cfg.write_value) begin
                err = mrrc_pkg::ERR_DATA;
            end else if (cfg.operation == mrrc_pkg::OP_WRITE_MULTI &&
                         word45 != cfg.write_count) begin
                err = mrrc_pkg::ERR_WRITE_COUNT;
            end
        end else begin
            // The unused operation code behaves as a read.
            if (over || frame_len < 9'd5 ||
                frame_len != 9'd5 + {1'b0, hdr_cur[2]}) begin
                err = mrrc_pkg::ERR_LENGTH;
            end else if (hdr_cur[2] != {cfg.read_count, 1'b0}) begin
                err = mrrc_pkg::ERR_READ_COUNT;
            end else if (hdr_cur[0] != cfg.station_id ||
                         hdr_cur[1] != mrrc_pkg::FC_READ_HOLDING) begin
                err = mrrc_pkg::ERR_HEADER;
            end else if (!crc_ok) begin
                err = mrrc_pkg::ERR_CRC;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= 8'd0;
            for (int k = 0; k < 6; k++) begin
                hdr_reg[k] <= 8'd0;
            end
            crc_now_reg   <= mrrc_pkg::CRC_INIT;
            crc_hist_reg  <= mrrc_pkg::CRC_INIT;
            prev_byte_reg <= 8'd0;
            too_long_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                if (in_word.last) begin
                    byte_index_reg <= 8'd0;
                    for (int k = 0; k < 6; k++) begin
                        hdr_reg[k] <= 8'd0;
                    end
                    crc_now_reg   <= mrrc_pkg::CRC_INIT;
                    crc_hist_reg  <= mrrc_pkg::CRC_INIT;
                    prev_byte_reg <= 8'd0;
                    too_long_reg  <= 1'b0;
                end else begin
                    for (int k = 0; k < 6; k++) begin
                        hdr_reg[k] <= hdr_cur[k];
                    end
                    crc_hist_reg  <= crc_now_reg;
                    crc_now_reg   <= mrrc_pkg::crc_feed(crc_now_reg, in_word.data);
                    prev_byte_reg <= in_word.data;
                    if (byte_index_reg == mrrc_pkg::INDEX_MAX) begin
                        too_long_reg <= 1'b1;
                    end else begin
                        byte_index_reg <= byte_index_reg + 8'd1;
                    end
                end
            end
            if (advance && in_word.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_word.last) begin
            result_reg.valid_res  <= (err == mrrc_pkg::ERR_OK);
            result_reg.error_code <= err;
        end
    end

    a_verdict_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (result_reg.valid_res == (result_reg.error_code == mrrc_pkg::ERR_OK)))
        else $error("verdict flag disagrees with error code");

    a_frame_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_word.last) |=>
            (byte_index_reg == 8'd0 && crc_now_reg == mrrc_pkg::CRC_INIT && !too_long_reg))
        else $error("frame state not cleared after final word");

    a_too_long_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        too_long_reg |-> (byte_index_reg == mrrc_pkg::INDEX_MAX))
        else $error("overlong flag set before byte index saturated");

    a_no_verdict_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_word.last) |-> (!m_valid_reg || m_ready))
        else $error("verdict overwritten while still pending");

endmodule

`default_nettype wire

@@ rtl/modbus_rtu_response_checker_top.sv @@
`default_nettype none

// Modbus RTU reply checker. Reply bytes enter one word per cycle on the s_ channel, with
// s_last on the final byte of the frame; a byte can be taken every clock. On the final
// byte a single verdict (pass flag and error code) appears on the m_ channel: the byte
// is captured in the input register, and once the core accepts it, the check logic loads
// the result register. A final byte waits in the input register while the previous verdict
// has not yet been taken, and intake stalls meanwhile. Configuration registers are written
// through the cfg_ channel by index and should only change while no frame is in flight.
module modbus_rtu_response_checker_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_valid_res,
    output logic [2:0]       m_error_code
);

    mrrc_pkg::cfg_t     cfg;
    mrrc_pkg::in_word_t in_reg;
    mrrc_pkg::result_t  result;
    logic               core_ready;

    assign s_ready = !in_reg.valid || core_ready;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.data <= s_rx_byte;
            in_reg.last <= s_last;
        end
        if (!aresetn) begin
            in_reg.valid <= 1'b0;
        end else if (s_ready) begin
            in_reg.valid <= s_valid;
        end
    end

    mrrc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mrrc_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_word  (in_reg),
        .in_ready (core_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .result   (result)
    );

    assign m_valid_res  = result.valid_res;
    assign m_error_code = result.error_code;

endmodule

`default_nettype wire

@@ bench/reply_tb_pkg.sv @@
`timescale 1ns / 1ps

package reply_tb_pkg;

    import mrrc_pkg::*;

    // Modbus CRC-16 advanced by one byte, least significant bit first.
    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                    input logic [7:0]  data);
        logic [15:0] acc;
        int k;
        acc = crc ^ {8'h00, data};
        for (k = 0; k < 8; k++) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

endpackage

@@ bench/reply_verdict_checker.sv @@
`timescale 1ns / 1ps

module reply_verdict_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_last,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_valid_res,
    input  wire logic [2:0]  m_error_code,
    output int               fail_count,
    output int               pending_verdicts
);

    import mrrc_pkg::*;
    import reply_tb_pkg::*;

    cfg_t       cfg;
    logic [7:0] frame_bytes;
    logic [7:0] head [0:5];
    logic [15:0] crc_run;
    logic [15:0] crc_prev;
    logic [7:0] prior_byte;
    logic       overflow;
    result_t    verdict_q [$];

    task automatic clear_frame();
        int i;
        frame_bytes = 8'd0;
        for (i = 0; i < 6; i++) begin
            head[i] = 8'd0;
        end
        crc_run    = CRC_INIT;
        crc_prev   = CRC_INIT;
        prior_byte = 8'd0;
        overflow   = 1'b0;
    endtask

    // Folds one accepted word into the frame state; the final word yields a verdict.
    task automatic take_byte(input logic [7:0] b, input logic is_last);
        int          len;
        logic        over;
        logic        crc_ok;
        logic        single;
        logic [7:0]  fc;
        logic [15:0] addr;
        logic [15:0] word45;
        logic [2:0]  err;
        result_t     v;
        if (!is_last) begin
            if (frame_bytes < 6) begin
                head[frame_bytes[2:0]] = b;
            end
            crc_prev   = crc_run;
            crc_run    = modbus_crc_byte(crc_run, b);
            prior_byte = b;
            if (frame_bytes == INDEX_MAX) begin
                overflow = 1'b1;
            end else begin
                frame_bytes = frame_bytes + 8'd1;
            end
            return;
        end
        over = overflow || (frame_bytes == INDEX_MAX);
        if (frame_bytes < 6) begin
            head[frame_bytes[2:0]] = b;
        end
        len = frame_bytes + 1;
        // The trailer is compared with the CRC taken before the final two bytes.
        crc_ok = (len >= 2) && (prior_byte == crc_prev[7:0]) && (b == crc_prev[15:8]);
        addr   = {head[2], head[3]};
        word45 = {head[4], head[5]};
        if (cfg.operation == OP_WRITE_SINGLE || cfg.operation == OP_WRITE_MULTI) begin
            single = (cfg.operation == OP_WRITE_SINGLE);
            fc = single ? FC_WRITE_SINGLE : FC_WRITE_MULTI;
            if (over || len != 8) begin
                err = ERR_LENGTH;
            end else if (head[0] != cfg.station_id || head[1] != fc) begin
                err = ERR_HEADER;
            end else if (!crc_ok) begin
                err = ERR_CRC;
            end else if (addr != cfg.start_address) begin
                err = ERR_ADDRESS;
            end else if (single && word45 != cfg.write_value) begin
                err = ERR_DATA;
            end else if (!single && word45 != cfg.write_count) begin
                err = ERR_WRITE_COUNT;
            end else begin
                err = ERR_OK;
            end
        end else begin
            if (over || len < 5 || len != 5 + head[2]) begin
                err = ERR_LENGTH;
            end else if (head[2] != 2 * cfg.read_count) begin
                err = ERR_READ_COUNT;
            end else if (head[0] != cfg.station_id || head[1] != FC_READ_HOLDING) begin
                err = ERR_HEADER;
            end else if (!crc_ok) begin
                err = ERR_CRC;
            end else begin
                err = ERR_OK;
            end
        end
        v.valid_res  = (err == ERR_OK);
        v.error_code = err;
        verdict_q = {verdict_q, v};
        clear_frame();
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            cfg.station_id    = 8'd1;
            cfg.operation     = OP_READ;
            cfg.start_address = 16'd0;
            cfg.read_count    = 7'd1;
            cfg.write_value   = 16'd0;
            cfg.write_count   = 16'd0;
            clear_frame();
            verdict_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: unexpected verdict: expected none, got valid_res=%0b error_code=%0d",
                             $time, m_valid_res, m_error_code);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_valid_res !== want.valid_res) begin
                        fail_count++;
                        $display("%0t ns: valid_res mismatch: expected %0b, got %0b",
                                 $time, want.valid_res, m_valid_res);
                    end
                    if (m_error_code !== want.error_code) begin
                        fail_count++;
                        $display("%0t ns: error_code mismatch: expected %0d, got %0d",
                                 $time, want.error_code, m_error_code);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_STATION_ID:    cfg.station_id    = cfg_data[7:0];
                    REG_OPERATION:     cfg.operation     = cfg_data[1:0];
                    REG_START_ADDRESS: cfg.start_address = cfg_data;
                    REG_READ_COUNT:    cfg.read_count    = cfg_data[6:0];
                    REG_WRITE_VALUE:   cfg.write_value   = cfg_data;
                    REG_WRITE_COUNT:   cfg.write_count   = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                take_byte(s_rx_byte, s_last);
            end
        end
        pending_verdicts = verdict_q.size();
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import mrrc_pkg::*;
    import reply_tb_pkg::*;

    localparam logic [1:0] OP_SPARE      = 2'd3;
    localparam logic [2:0] REG_UNUSED_LO = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    localparam int SETTLE_CYCLES = 4;
    localparam int BYTE_TARGET   = 1700;
    localparam int HOLD_CYCLES   = 300;

    // Ways a generated reply can deviate from a correct one.
    localparam int FLAW_NONE        = 0;
    localparam int FLAW_STATION     = 1;
    localparam int FLAW_FUNCTION    = 2;
    localparam int FLAW_FIELD_A     = 3;
    localparam int FLAW_FIELD_B     = 4;
    localparam int FLAW_CRC         = 5;
    localparam int FLAW_DROP        = 6;
    localparam int FLAW_EXTRA       = 7;
    localparam int FLAW_FOREIGN_FC  = 8;
    localparam int FLAW_SHORT_NOISE = 9;
    localparam int FLAW_LONG_NOISE  = 10;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data  = 16'd0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        s_last    = 1'b0;
    logic        m_ready   = 1'b0;
    wire         cfg_ready;
    wire         s_ready;
    wire         m_valid;
    wire         m_valid_res;
    wire  [2:0]  m_error_code;

    int fail_count;
    int pending_verdicts;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int bytes_sent    = 0;

    // Settings the block currently holds, used to shape replies.
    logic [7:0]  station      = 8'd1;
    logic [1:0]  op_mode      = OP_READ;
    logic [15:0] reg_addr     = 16'd0;
    logic [6:0]  reg_count    = 7'd1;
    logic [15:0] single_value = 16'd0;
    logic [15:0] multi_count  = 16'd0;

    logic [7:0] frame_q [$];

    modbus_rtu_response_checker_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_valid_res  (m_valid_res),
        .m_error_code (m_error_code)
    );

    reply_verdict_checker verdict_chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_valid_res      (m_valid_res),
        .m_error_code     (m_error_code),
        .fail_count       (fail_count),
        .pending_verdicts (pending_verdicts)
    );

    always #5 aclk = ~aclk;

    // Result-side backpressure; a requested hold-off keeps ready low for a long stretch.
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("modbus_rtu_response_checker_top verification failed");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        logic [7:0] r;
        r = 8'($urandom);
        return r;
    endfunction

    // Random word that lands on either extreme a fair share of the time.
    function automatic logic [15:0] biased_word();
        logic [15:0] w;
        int pick;
        pick = $urandom_range(0, 3);
        w = 16'($urandom);
        if (pick == 0) begin
            w = 16'h0000;
        end else if (pick == 1) begin
            w = 16'hFFFF;
        end
        return w;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Settings only change once every verdict is back and the pipeline has drained.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_verdicts != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic configure(input logic [7:0] st, input logic [1:0] op,
                             input logic [15:0] ad, input logic [6:0] rc,
                             input logic [15:0] wv, input logic [15:0] wc);
        logic [15:0] junk;
        wait_idle();
        junk = 16'($urandom);
        // Narrow registers get random upper bits, which the block must drop.
        write_reg(REG_STATION_ID, {junk[15:8], st});
        write_reg(REG_OPERATION, {junk[15:2], op});
        write_reg(REG_START_ADDRESS, ad);
        write_reg(REG_READ_COUNT, {junk[8:0], rc});
        write_reg(REG_WRITE_VALUE, wv);
        write_reg(REG_WRITE_COUNT, wc);
        station      = st;
        op_mode      = op;
        reg_addr     = ad;
        reg_count    = rc;
        single_value = wv;
        multi_count  = wc;
    endtask

    task automatic random_config();
        logic [15:0] w;
        logic [7:0]  st;
        logic [6:0]  rc;
        int pick;
        w = biased_word();
        st = w[7:0];
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            rc = 7'd127;
        end else if (pick == 1) begin
            rc = 7'($urandom_range(8, 126));
        end else begin
            rc = 7'($urandom_range(0, 6));
        end
        configure(st, 2'($urandom_range(0, 3)), biased_word(), rc, biased_word(),
                  biased_word());
    endtask

    task automatic append_crc();
        logic [15:0] c;
        int i;
        c = CRC_INIT;
        for (i = 0; i < frame_q.size(); i++) begin
            c = modbus_crc_byte(c, frame_q[i]);
        end
        frame_q = {frame_q, c[7:0]};
        frame_q = {frame_q, c[15:8]};
    endtask

    task automatic build_frame(input int flaw);
        int n;
        int i;
        int bc;
        logic [7:0]  st;
        logic [7:0]  fc;
        logic [7:0]  flip8;
        logic [15:0] w23;
        logic [15:0] w45;
        frame_q.delete();
        if (flaw == FLAW_SHORT_NOISE || flaw == FLAW_LONG_NOISE) begin
            if (flaw == FLAW_SHORT_NOISE) begin
                n = $urandom_range(1, 12);
            end else if ($urandom_range(0, 1) == 0) begin
                n = $urandom_range(253, 258);
            end else begin
                n = $urandom_range(259, 300);
            end
            repeat (n) frame_q = {frame_q, rand_byte()};
            return;
        end
        flip8 = 8'($urandom_range(1, 255));
        st = (flaw == FLAW_STATION) ? (station ^ flip8) : station;
        if (op_mode == OP_WRITE_SINGLE || op_mode == OP_WRITE_MULTI) begin
            fc = (op_mode == OP_WRITE_SINGLE) ? FC_WRITE_SINGLE : FC_WRITE_MULTI;
            if (flaw == FLAW_FOREIGN_FC) begin
                fc = (op_mode == OP_WRITE_SINGLE) ? FC_WRITE_MULTI : FC_READ_HOLDING;
            end
            w23 = reg_addr;
            w45 = (op_mode == OP_WRITE_SINGLE) ? single_value : multi_count;
            if (flaw == FLAW_FIELD_A) begin
                w23 = w23 ^ 16'($urandom_range(1, 65535));
            end
            if (flaw == FLAW_FIELD_B) begin
                w45 = w45 ^ 16'($urandom_range(1, 65535));
            end
            if (flaw == FLAW_FUNCTION) begin
                fc = fc ^ flip8;
            end
            frame_q = {frame_q, st};
            frame_q = {frame_q, fc};
            frame_q = {frame_q, w23[15:8]};
            frame_q = {frame_q, w23[7:0]};
            frame_q = {frame_q, w45[15:8]};
            frame_q = {frame_q, w45[7:0]};
        end else begin
            fc = (flaw == FLAW_FOREIGN_FC) ? FC_WRITE_SINGLE : FC_READ_HOLDING;
            if (flaw == FLAW_FUNCTION) begin
                fc = fc ^ flip8;
            end
            bc = 2 * reg_count;
            if (flaw == FLAW_FIELD_A) begin
                // Byte count disagrees with the request but matches the frame length.
                bc = $urandom_range(0, 30);
                if (bc == 2 * reg_count) begin
                    bc++;
                end
            end
            n = bc;
            if (flaw == FLAW_FIELD_B) begin
                n = bc + $urandom_range(1, 3);
            end
            frame_q = {frame_q, st};
            frame_q = {frame_q, fc};
            frame_q = {frame_q, bc[7:0]};
            repeat (n) frame_q = {frame_q, rand_byte()};
        end
        if (flaw == FLAW_DROP) begin
            void'(frame_q.pop_back());
        end
        if (flaw == FLAW_EXTRA) begin
            frame_q = {frame_q, rand_byte()};
        end
        append_crc();
        if (flaw == FLAW_CRC) begin
            i = frame_q.size() - 1 - $urandom_range(0, 1);
            frame_q[i] = frame_q[i] ^ flip8;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid   <= 1'b0;
            s_rx_byte <= rand_byte();
            s_last    <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge aclk);
        end
        s_rx_byte <= b;
        s_last    <= is_last;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++) begin
            push_byte(frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    initial begin
        int phase;
        int frames;
        int phase_start;
        int group_start;
        int k;
        int flaw;
        bit held;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 29;
        recv_idle_pct = 86;

        // A frame of a single word cannot carry a CRC and fails on length.
        frame_q.delete();
        frame_q = {frame_q, 8'hFF};
        send_frame();
        // Correct read reply against the settings the block comes out of reset with.
        build_frame(FLAW_NONE);
        send_frame();

        configure(8'hFF, OP_WRITE_MULTI, 16'hFFFF, 7'd127, 16'hFFFF, 16'hFFFF);
        // Writes to indexes past the last register must leave everything unchanged.
        write_reg(REG_UNUSED_LO, 16'h0000);
        write_reg(REG_UNUSED_HI, 16'hFFFF);
        build_frame(FLAW_NONE);
        send_frame();

        // The spare operation code checks a read reply.
        configure(8'h00, OP_SPARE, 16'h0000, 7'd0, 16'h0000, 16'h0000);
        build_frame(FLAW_NONE);
        send_frame();

        configure(8'h5A, OP_WRITE_SINGLE, 16'h8001, 7'd1, 16'h7FFE, 16'h0000);
        build_frame(FLAW_NONE);
        send_frame();

        for (phase = 0; phase < 3; phase++) begin
            if (phase == 0) begin
                send_idle_pct = 29;
                recv_idle_pct = 86;
            end else if (phase == 1) begin
                send_idle_pct = 86;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            held = 1'b0;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < BYTE_TARGET / 3) begin
                random_config();
                frames = 0;
                group_start = bytes_sent;
                while (frames < 12 && bytes_sent - group_start < 150) begin
                    if (frames == 2 && !held) begin
                        hold_request = HOLD_CYCLES;
                        held = 1'b1;
                    end
                    k = $urandom_range(0, 99);
                    if (k < 55) begin
                        flaw = FLAW_NONE;
                    end else if (k < 89) begin
                        flaw = $urandom_range(FLAW_STATION, FLAW_FOREIGN_FC);
                    end else if (k < 99) begin
                        flaw = FLAW_SHORT_NOISE;
                    end else begin
                        flaw = FLAW_LONG_NOISE;
                    end
                    build_frame(flaw);
                    send_frame();
                    frames++;
                end
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending_verdicts == 0) begin
            $display("modbus_rtu_response_checker_top verification clean");
        end else begin
            $display("modbus_rtu_response_checker_top verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mrrc_pkg.sv
rtl/mrrc_cfg.sv
rtl/mrrc_core.sv
rtl/modbus_rtu_response_checker_top.sv
bench/reply_tb_pkg.sv
bench/reply_verdict_checker.sv
bench/testbench.sv
